>>> src/msdh_pkg.sv
// ----------------------------------------------------------------------------
// msdh_pkg
// Shared types, codes and defaults of the multi-switch debounce hold timer.
// ----------------------------------------------------------------------------
package msdh_pkg;

  // default lane count
  localparam int NUM_SWITCHES_DEF = 3;

  // fixed field widths
  localparam int PIN_W      = 3;
  localparam int SEL_W      = 2;
  localparam int STATE_W    = 2;
  localparam int COUNT_W    = 6;
  localparam int TICK_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int STATES_W   = 6;
  localparam int HOLDS_W    = 18;

  // lanes that fit into the packed outputs
  localparam int PACK_LANES = STATES_W / STATE_W;

  // item opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_FORCE = 1'b1;

  // switch states
  localparam logic [STATE_W-1:0] ST_RELEASED    = 2'd0;
  localparam logic [STATE_W-1:0] ST_PREPRESSED  = 2'd1;
  localparam logic [STATE_W-1:0] ST_PRESSED     = 2'd2;
  localparam logic [STATE_W-1:0] ST_PRERELEASED = 2'd3;

  // pin levels, active low
  localparam logic LEVEL_PRESSED  = 1'b0;
  localparam logic LEVEL_RELEASED = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SAMPLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOLD_SECONDS   = 2'd2;

  // register reset values
  localparam logic [TICK_W-1:0]  TICKS_PER_SAMPLE_RST   = 8'd4;
  localparam logic [COUNT_W-1:0] SAMPLES_PER_SECOND_RST = 6'd50;
  localparam logic [COUNT_W-1:0] MAX_HOLD_SECONDS_RST   = 6'd60;

  // timing settings seen by every lane
  typedef struct packed {
    logic [COUNT_W-1:0] samples_per_second;
    logic [COUNT_W-1:0] max_hold_seconds;
  } lane_cfg_t;

  // per-lane control for one item
  typedef struct packed {
    logic               sample;
    logic               level;
    logic               force_en;
    logic [STATE_W-1:0] force_state;
  } lane_ctrl_t;

endpackage

>>> src/multi_switch_debounce_hold_timer_core.sv
// ----------------------------------------------------------------------------
// multi_switch_debounce_hold_timer_core
// Three-switch debouncer with per-switch hold timers, one lane per switch.
// ----------------------------------------------------------------------------
// Result: an accepted item's result item is registered and shown on the output in the next cycle.
// Throughput: 1 item per cycle; all lanes update in parallel and a new item
//   enters in the cycle the previous result leaves. A stalled result stalls
//   the input until it is taken.
// Reset: asynchronous, active low; clears the divider, all lanes and the
//   output valid, and loads the register defaults. No clearing pass.
module multi_switch_debounce_hold_timer_core #(
  parameter int NumSwitches = msdh_pkg::NUM_SWITCHES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [msdh_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [msdh_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input items
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               opcode_i,
  input  logic [msdh_pkg::PIN_W-1:0]         pin_levels_i,
  input  logic [msdh_pkg::SEL_W-1:0]         switch_select_i,
  input  logic [msdh_pkg::STATE_W-1:0]       new_state_i,
  // result items
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               sampled_o,
  output logic [msdh_pkg::STATES_W-1:0]      states_packed_o,
  output logic [msdh_pkg::HOLDS_W-1:0]       hold_seconds_packed_o
);

  logic [msdh_pkg::TICK_W-1:0]  ticks_per_sample_q;
  logic [msdh_pkg::COUNT_W-1:0] samples_per_second_q;
  logic [msdh_pkg::COUNT_W-1:0] max_hold_seconds_q;
  logic [msdh_pkg::TICK_W-1:0]  tick_div_q, tick_div_d;
  logic [msdh_pkg::TICK_W:0]    tick_inc;
  logic                         accept;
  logic                         is_tick;
  logic                         take_sample;
  msdh_pkg::lane_cfg_t          lane_cfg;

  logic [NumSwitches-1:0][msdh_pkg::STATE_W-1:0] lane_state;
  logic [NumSwitches-1:0][msdh_pkg::COUNT_W-1:0] lane_hold;

  // handshake
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_o && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign is_tick     = (opcode_i == msdh_pkg::OP_TICK);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_per_sample_q   <= msdh_pkg::TICKS_PER_SAMPLE_RST;
      samples_per_second_q <= msdh_pkg::SAMPLES_PER_SECOND_RST;
      max_hold_seconds_q   <= msdh_pkg::MAX_HOLD_SECONDS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        msdh_pkg::CFG_TICKS_PER_SAMPLE: begin
          ticks_per_sample_q <= cfg_data_i;
        end
        msdh_pkg::CFG_SAMPLES_PER_SECOND: begin
          samples_per_second_q <= cfg_data_i[msdh_pkg::COUNT_W-1:0];
        end
        msdh_pkg::CFG_MAX_HOLD_SECONDS: begin
          max_hold_seconds_q <= cfg_data_i[msdh_pkg::COUNT_W-1:0];
        end
        default: begin
          ticks_per_sample_q <= ticks_per_sample_q;
        end
      endcase
    end
  end

  assign lane_cfg.samples_per_second = samples_per_second_q;
  assign lane_cfg.max_hold_seconds   = max_hold_seconds_q;

  // tick divider
  always_comb begin
    tick_inc    = {1'b0, tick_div_q} + {{msdh_pkg::TICK_W{1'b0}}, 1'b1};
    take_sample = 1'b0;
    tick_div_d  = tick_div_q;
    if (accept && is_tick) begin
      if (tick_inc >= {1'b0, ticks_per_sample_q}) begin
        take_sample = 1'b1;
        tick_div_d  = '0;
      end else begin
        tick_div_d  = tick_inc[msdh_pkg::TICK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_div_q <= '0;
    end else begin
      tick_div_q <= tick_div_d;
    end
  end

  // switch lanes
  for (genvar g = 0; g < NumSwitches; g++) begin : g_lane
    msdh_pkg::lane_ctrl_t ctrl;

    if (g < msdh_pkg::PIN_W) begin : g_pin
      assign ctrl.level = pin_levels_i[g];
    end else begin : g_no_pin
      assign ctrl.level = msdh_pkg::LEVEL_RELEASED;
    end

    assign ctrl.sample      = take_sample;
    assign ctrl.force_en    = accept && !is_tick && (int'(switch_select_i) == g);
    assign ctrl.force_state = new_state_i;

    msdh_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .cfg_i     (lane_cfg),
      .state_d_o (lane_state[g]),
      .hold_d_o  (lane_hold[g])
    );
  end

  // result packing and output register
  msdh_merge #(
    .NumSwitches (NumSwitches)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .sampled_i    (take_sample),
    .lane_state_i (lane_state),
    .lane_hold_i  (lane_hold),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .sampled_o    (sampled_o),
    .states_o     (states_packed_o),
    .holds_o      (hold_seconds_packed_o)
  );

  // every accepted item shows up as a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted item produced no result");

  // force items never report a sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_tick) |=> !sampled_o)
    else $error("force item reported a sample");

  // a sample restarts the divider
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_sample |=> (tick_div_q == '0))
    else $error("divider not restarted after sample");

endmodule

>>> src/msdh_lane.sv
// ----------------------------------------------------------------------------
// msdh_lane
// One switch: previous sample, four-state debounce machine and hold counters.
// ----------------------------------------------------------------------------
module msdh_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  msdh_pkg::lane_ctrl_t                ctrl_i,
  input  msdh_pkg::lane_cfg_t                 cfg_i,
  output logic [msdh_pkg::STATE_W-1:0]        state_d_o,
  output logic [msdh_pkg::COUNT_W-1:0]        hold_d_o
);

  logic                          prev_q, prev_d;
  logic [msdh_pkg::STATE_W-1:0]  state_q, state_d;
  logic [msdh_pkg::COUNT_W-1:0]  sub_q, sub_d;
  logic [msdh_pkg::COUNT_W-1:0]  hold_q, hold_d;
  logic [msdh_pkg::COUNT_W:0]    sub_inc;

  // next state of the debounce machine
  always_comb begin
    prev_d  = prev_q;
    state_d = state_q;
    sub_d   = sub_q;
    hold_d  = hold_q;
    sub_inc = {1'b0, sub_q} + {{msdh_pkg::COUNT_W{1'b0}}, 1'b1};
    if (ctrl_i.force_en) begin
      state_d = ctrl_i.force_state;
    end else if (ctrl_i.sample) begin
      prev_d = ctrl_i.level;
      unique case (state_q)
        msdh_pkg::ST_RELEASED: begin
          if (prev_q == msdh_pkg::LEVEL_PRESSED &&
              ctrl_i.level == msdh_pkg::LEVEL_PRESSED) begin
            state_d = msdh_pkg::ST_PREPRESSED;
          end
        end
        msdh_pkg::ST_PREPRESSED: begin
          if (ctrl_i.level == msdh_pkg::LEVEL_PRESSED) begin
            state_d = msdh_pkg::ST_PRESSED;
          end
        end
        msdh_pkg::ST_PRESSED: begin
          if (ctrl_i.level == msdh_pkg::LEVEL_PRESSED) begin
            // sub-second wrap raises the saturating seconds count
            if (sub_inc >= {1'b0, cfg_i.samples_per_second}) begin
              sub_d = '0;
              if (hold_q < cfg_i.max_hold_seconds) begin
                hold_d = hold_q + {{(msdh_pkg::COUNT_W-1){1'b0}}, 1'b1};
              end
            end else begin
              sub_d = sub_inc[msdh_pkg::COUNT_W-1:0];
            end
          end else if (prev_q == msdh_pkg::LEVEL_RELEASED) begin
            state_d = msdh_pkg::ST_PRERELEASED;
            sub_d   = '0;
            hold_d  = '0;
          end
        end
        msdh_pkg::ST_PRERELEASED: begin
          if (ctrl_i.level == msdh_pkg::LEVEL_RELEASED) begin
            state_d = msdh_pkg::ST_RELEASED;
          end
        end
        default: begin
          state_d = state_q;
        end
      endcase
    end
  end

  // lane registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= msdh_pkg::LEVEL_RELEASED;
      state_q <= msdh_pkg::ST_RELEASED;
      sub_q   <= '0;
      hold_q  <= '0;
    end else begin
      prev_q  <= prev_d;
      state_q <= state_d;
      sub_q   <= sub_d;
      hold_q  <= hold_d;
    end
  end

  assign state_d_o = state_d;
  assign hold_d_o  = hold_d;

endmodule

>>> src/msdh_merge.sv
// ----------------------------------------------------------------------------
// msdh_merge
// Packs the lane states and hold counts into one result item register.
// ----------------------------------------------------------------------------
module msdh_merge #(
  parameter int NumSwitches = msdh_pkg::NUM_SWITCHES_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         accept_i,
  input  logic                                         sampled_i,
  input  logic [NumSwitches-1:0][msdh_pkg::STATE_W-1:0] lane_state_i,
  input  logic [NumSwitches-1:0][msdh_pkg::COUNT_W-1:0] lane_hold_i,
  input  logic                                         out_stall_i,
  output logic                                         out_valid_o,
  output logic                                         sampled_o,
  output logic [msdh_pkg::STATES_W-1:0]                states_o,
  output logic [msdh_pkg::HOLDS_W-1:0]                 holds_o
);

  localparam int PackLanes = (NumSwitches < msdh_pkg::PACK_LANES) ?
                             NumSwitches : msdh_pkg::PACK_LANES;

  logic                          valid_q, valid_d;
  logic                          sampled_q;
  logic [msdh_pkg::STATES_W-1:0] states_q, states_d;
  logic [msdh_pkg::HOLDS_W-1:0]  holds_q, holds_d;

  // pack lanes that have room, others drop out
  always_comb begin
    states_d = '0;
    holds_d  = '0;
    for (int i = 0; i < PackLanes; i++) begin
      states_d[msdh_pkg::STATE_W*i +: msdh_pkg::STATE_W] = lane_state_i[i];
      holds_d[msdh_pkg::COUNT_W*i +: msdh_pkg::COUNT_W]  = lane_hold_i[i];
    end
  end

  // output valid: set on a new item, held while stalled
  always_comb begin
    if (accept_i) begin
      valid_d = 1'b1;
    end else if (out_stall_i) begin
      valid_d = valid_q;
    end else begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      sampled_q <= sampled_i;
      states_q  <= states_d;
      holds_q   <= holds_d;
    end
  end

  assign out_valid_o = valid_q;
  assign sampled_o   = sampled_q;
  assign states_o    = states_q;
  assign holds_o     = holds_q;

endmodule
